@@ design/rtt_pkg.sv @@
// shared constants, command and status codes for the rectangle track table
// no dependencies
package rtt_pkg;

  localparam int TableEntriesDef = 16;
  localparam int CoordBitsDef    = 12;
  localparam int ThrBits         = 9;
  localparam int TagBits         = 16;
  localparam int ClsBits         = 8;

  localparam logic [ThrBits-1:0] MatchThrRst = 9'd128;
  localparam logic [ThrBits-1:0] MergeThrRst = 9'd179;

  localparam logic [2:0] CmdInsert  = 3'd0;
  localparam logic [2:0] CmdQuery   = 3'd1;
  localparam logic [2:0] CmdReplace = 3'd2;
  localparam logic [2:0] CmdRemove  = 3'd3;
  localparam logic [2:0] CmdClean   = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNone    = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StBadSlot = 2'd3;

  localparam logic CfgMatch = 1'b0;
  localparam logic CfgMerge = 1'b1;

  typedef enum logic [2:0] {
    MulNone,
    MulOv,
    MulAreaA,
    MulAreaB,
    MulThr
  } mul_op_e;

endpackage

@@ design/rtt_arith.sv @@
// shared arithmetic unit: registered box intersection and one registered multiplier
// depends on rtt_pkg
module rtt_arith #(
  parameter int CoordBits = rtt_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  rtt_pkg::mul_op_e             op_i,
  input  logic [4*CoordBits-1:0]       a_box_i,
  input  logic [4*CoordBits-1:0]       b_box_i,
  input  logic [2*CoordBits-1:0]       area_i,
  input  logic [rtt_pkg::ThrBits-1:0]  thr_i,
  output logic [3*CoordBits:0]         prod_o
);
  import rtt_pkg::*;

  localparam int CB = CoordBits;

  logic [CB-1:0]   ax, ay, aw, ah, bx, by, bw, bh;
  logic [CB-1:0]   ow_d, oh_d, ow_q, oh_q;
  logic [CB:0]     x_lo, x_hi, y_lo, y_hi, ax2, bx2, ay2, by2;
  logic [2*CB-1:0] mul_a;
  logic [CB:0]     mul_b;
  logic [3*CB:0]   prod_q;

  assign {ax, ay, aw, ah} = a_box_i;
  assign {bx, by, bw, bh} = b_box_i;

  assign ax2  = (CB+1)'(ax) + (CB+1)'(aw);
  assign bx2  = (CB+1)'(bx) + (CB+1)'(bw);
  assign ay2  = (CB+1)'(ay) + (CB+1)'(ah);
  assign by2  = (CB+1)'(by) + (CB+1)'(bh);
  assign x_lo = (ax > bx) ? (CB+1)'(ax) : (CB+1)'(bx);
  assign y_lo = (ay > by) ? (CB+1)'(ay) : (CB+1)'(by);
  assign x_hi = (ax2 < bx2) ? ax2 : bx2;
  assign y_hi = (ay2 < by2) ? ay2 : by2;

  // empty intersection on either axis gives zero overlap
  always_comb begin
    ow_d = '0;
    oh_d = '0;
    if (x_hi > x_lo && y_hi > y_lo) begin
      ow_d = CB'(x_hi - x_lo);
      oh_d = CB'(y_hi - y_lo);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      MulOv: begin
        mul_a = (2*CB)'(ow_q);
        mul_b = (CB+1)'(oh_q);
      end
      MulAreaA: begin
        mul_a = (2*CB)'(aw);
        mul_b = (CB+1)'(ah);
      end
      MulAreaB: begin
        mul_a = (2*CB)'(bw);
        mul_b = (CB+1)'(bh);
      end
      MulThr: begin
        mul_a = area_i;
        mul_b = (CB+1)'(thr_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ow_q   <= ow_d;
    oh_q   <= oh_d;
    prod_q <= (3*CB+1)'(mul_a) * (3*CB+1)'(mul_b);
  end

  assign prod_o = prod_q;

endmodule

@@ design/rectangle_track_table.sv @@
// rectangle track table top level: command sequencer, table memory, config registers
// depends on rtt_pkg and rtt_arith
//
// usage: one command word enters on the in channel (valid/ready) and gives exactly
// one result word on the out channel (valid/ready). in_ready_o is high only while
// the sequencer is idle; the block works on one command at a time.
// how each command proceeds (one shared multiplier, one table read at a time):
//   insert, bad slot, unknown command: answered at dispatch
//   query: walks the entries in order and stops at the first match
//   remove / replace: shifts every later entry down; replace then writes the new box last
//   clean: compares every ordered pair of entries, then shifts out the chosen entry
// the result sits in an output register; the next command is taken while it waits.
// when the receiver stalls, a finished command waits in its last step until the
// output register frees, and no new command is taken meanwhile.
// reset empties the table, zeroes the tag counter and loads the default
// thresholds; table contents are not cleared and no clearing pass is needed.
// cfg_we_i writes threshold cfg_index_i (0 match, 1 merge).
module rectangle_track_table #(
  parameter int TableEntries = rtt_pkg::TableEntriesDef,
  parameter int CoordBits    = rtt_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [rtt_pkg::ThrBits-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  command_i,
  input  logic [11:0]                 box_x_i,
  input  logic [11:0]                 box_y_i,
  input  logic [11:0]                 box_width_i,
  input  logic [11:0]                 box_height_i,
  input  logic [7:0]                  object_class_i,
  input  logic [3:0]                  slot_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [3:0]                  result_index_o,
  output logic [15:0]                 result_tag_o,
  output logic [7:0]                  result_class_o,
  output logic [4:0]                  entry_count_o
);
  import rtt_pkg::*;

  localparam int N  = TableEntries;
  localparam int CB = CoordBits;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam int LW = CW + 1;
  localparam int BW = 4 * CB;
  localparam int EW = BW + TagBits + ClsBits;
  localparam int PW = 3 * CB + 9;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_QAREA   = 5'd2;
  localparam logic [4:0] S_C_RD    = 5'd3;
  localparam logic [4:0] S_C_LD    = 5'd4;
  localparam logic [4:0] S_C_ISECT = 5'd5;
  localparam logic [4:0] S_C_OV    = 5'd6;
  localparam logic [4:0] S_C_AB    = 5'd7;
  localparam logic [4:0] S_C_T     = 5'd8;
  localparam logic [4:0] S_C_CMP   = 5'd9;
  localparam logic [4:0] S_C_CMP2  = 5'd10;
  localparam logic [4:0] S_K_RDI   = 5'd11;
  localparam logic [4:0] S_K_LDI   = 5'd12;
  localparam logic [4:0] S_K_AI    = 5'd13;
  localparam logic [4:0] S_K_AI2   = 5'd14;
  localparam logic [4:0] S_X_RD    = 5'd15;
  localparam logic [4:0] S_X_LD    = 5'd16;
  localparam logic [4:0] S_E_RD    = 5'd17;
  localparam logic [4:0] S_E_WR    = 5'd18;
  localparam logic [4:0] S_E_END   = 5'd19;
  localparam logic [4:0] S_DONE    = 5'd20;

  // control state
  logic [4:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [TagBits-1:0] tag_ctr_q, tag_ctr_d;
  logic [ThrBits-1:0] match_thr_q, merge_thr_q;
  logic               out_valid_q, out_valid_d;
  logic               found_q, found_d;

  // payload state
  logic [2:0]         cmd_q, cmd_d;
  logic [ClsBits-1:0] cls_in_q, cls_in_d;
  logic [3:0]         slot_q, slot_d;
  logic [BW-1:0]      ba_q, ba_d, bb_q, bb_d;
  logic [TagBits-1:0] bb_tag_q, bb_tag_d, sv_tag_q, sv_tag_d;
  logic [ClsBits-1:0] bb_cls_q, bb_cls_d, sv_cls_q, sv_cls_d;
  logic [2*CB-1:0]    area_a_q, area_a_d, ov_q, ov_d;
  logic               a_big_q, a_big_d;
  logic [LW-1:0]      i_q, i_d, j_q, j_d, n_q, n_d;
  logic [IW-1:0]      victim_q, victim_d;
  logic [1:0]         res_st_q, res_st_d, out_st_q, out_st_d;
  logic [3:0]         res_idx_q, res_idx_d, out_idx_q, out_idx_d;
  logic [TagBits-1:0] res_tag_q, res_tag_d, out_tag_q, out_tag_d;
  logic [ClsBits-1:0] res_cls_q, res_cls_d, out_cls_q, out_cls_d;
  logic [4:0]         out_cnt_q, out_cnt_d;

  // table memory
  logic [EW-1:0]      mem [N];
  logic [EW-1:0]      rdata_q;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr, rd_addr;
  logic [EW-1:0]      mem_wdata;
  logic [BW-1:0]      rd_box;
  logic [TagBits-1:0] rd_tag;
  logic [ClsBits-1:0] rd_cls;

  // shared unit
  mul_op_e            mul_op;
  logic [2*CB-1:0]    thr_area, prod_lo;
  logic [ThrBits-1:0] thr_sel;
  logic [3*CB:0]      prod;
  logic               hit;

  logic [LW-1:0]      cnt_l, j_inc, j_nxt, i_inc, n_inc;
  logic [CW-1:0]      cnt_m1;
  logic [IW-1:0]      vic_now, vic_sel;
  logic               found_now;

  assign rd_box = rdata_q[EW-1 -: BW];
  assign rd_tag = rdata_q[ClsBits +: TagBits];
  assign rd_cls = rdata_q[ClsBits-1:0];

  assign prod_lo   = prod[2*CB-1:0];
  assign hit       = PW'({ov_q, 8'd0}) > PW'(prod);
  assign thr_sel   = (cmd_q == CmdQuery) ? match_thr_q : merge_thr_q;
  assign cnt_l     = LW'(cnt_q);
  assign cnt_m1    = cnt_q - 1'b1;
  assign j_inc     = j_q + 1'b1;
  assign j_nxt     = (j_inc == i_q) ? j_q + LW'(2) : j_inc;
  assign i_inc     = i_q + 1'b1;
  assign n_inc     = n_q + 1'b1;
  assign vic_now   = a_big_q ? i_q[IW-1:0] : j_q[IW-1:0];
  assign vic_sel   = hit ? vic_now : victim_q;
  assign found_now = found_q | hit;

  rtt_arith #(
    .CoordBits(CB)
  ) u_arith (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .a_box_i(ba_q),
    .b_box_i(bb_q),
    .area_i (thr_area),
    .thr_i  (thr_sel),
    .prod_o (prod)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    tag_ctr_d   = tag_ctr_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    found_d     = found_q;
    cmd_d       = cmd_q;
    cls_in_d    = cls_in_q;
    slot_d      = slot_q;
    ba_d        = ba_q;
    bb_d        = bb_q;
    bb_tag_d    = bb_tag_q;
    bb_cls_d    = bb_cls_q;
    sv_tag_d    = sv_tag_q;
    sv_cls_d    = sv_cls_q;
    area_a_d    = area_a_q;
    ov_d        = ov_q;
    a_big_d     = a_big_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    victim_d    = victim_q;
    res_st_d    = res_st_q;
    res_idx_d   = res_idx_q;
    res_tag_d   = res_tag_q;
    res_cls_d   = res_cls_q;
    out_st_d    = out_st_q;
    out_idx_d   = out_idx_q;
    out_tag_d   = out_tag_q;
    out_cls_d   = out_cls_q;
    out_cnt_d   = out_cnt_q;
    mul_op      = MulNone;
    thr_area    = area_a_q;
    rd_addr     = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = command_i;
          ba_d      = {CB'(box_x_i), CB'(box_y_i), CB'(box_width_i), CB'(box_height_i)};
          cls_in_d  = object_class_i;
          slot_d    = slot_i;
          res_st_d  = StNone;
          res_idx_d = '0;
          res_tag_d = '0;
          res_cls_d = '0;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_q)
          CmdInsert: begin
            if (cnt_q == CW'(N)) begin
              res_st_d = StFull;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cnt_q[IW-1:0];
              mem_wdata = {ba_q, tag_ctr_q, cls_in_q};
              res_st_d  = StOk;
              res_idx_d = 4'(cnt_q);
              res_tag_d = tag_ctr_q;
              res_cls_d = cls_in_q;
              cnt_d     = cnt_q + 1'b1;
              tag_ctr_d = tag_ctr_q + 1'b1;
            end
            state_d = S_DONE;
          end
          CmdQuery: begin
            mul_op  = MulAreaA;
            state_d = S_QAREA;
          end
          CmdReplace, CmdRemove: begin
            if ((CW+4)'(slot_q) >= (CW+4)'(cnt_q)) begin
              res_st_d = StBadSlot;
              state_d  = S_DONE;
            end else begin
              n_d      = LW'(slot_q);
              victim_d = IW'(slot_q);
              state_d  = S_X_RD;
            end
          end
          CmdClean: begin
            if (cnt_q < CW'(2)) begin
              state_d = S_DONE;
            end else begin
              i_d     = '0;
              found_d = 1'b0;
              state_d = S_K_RDI;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_QAREA: begin
        area_a_d = prod_lo;
        j_d      = '0;
        state_d  = (cnt_q == '0) ? S_DONE : S_C_RD;
      end
      S_C_RD: begin
        rd_addr = j_q[IW-1:0];
        state_d = S_C_LD;
      end
      S_C_LD: begin
        bb_d     = rd_box;
        bb_tag_d = rd_tag;
        bb_cls_d = rd_cls;
        state_d  = S_C_ISECT;
      end
      S_C_ISECT: begin
        // intersection register settles on the new box
        state_d = S_C_OV;
      end
      S_C_OV: begin
        mul_op  = MulOv;
        state_d = S_C_AB;
      end
      S_C_AB: begin
        ov_d    = prod_lo;
        mul_op  = MulAreaB;
        state_d = S_C_T;
      end
      S_C_T: begin
        a_big_d = area_a_q > prod_lo;
        mul_op  = MulThr;
        if (cmd_q == CmdQuery) begin
          thr_area = prod_lo;
        end else begin
          thr_area = (area_a_q > prod_lo) ? area_a_q : prod_lo;
        end
        state_d = S_C_CMP;
      end
      S_C_CMP, S_C_CMP2: begin
        if (cmd_q == CmdQuery) begin
          if (hit) begin
            res_st_d  = StOk;
            res_idx_d = 4'(j_q);
            res_tag_d = bb_tag_q;
            res_cls_d = bb_cls_q;
            state_d   = S_DONE;
          end else if (state_q == S_C_CMP) begin
            // entry area failed, try the detection's own area
            mul_op   = MulThr;
            thr_area = area_a_q;
            state_d  = S_C_CMP2;
          end else if (j_inc >= cnt_l) begin
            state_d = S_DONE;
          end else begin
            j_d     = j_inc;
            state_d = S_C_RD;
          end
        end else begin
          found_d  = found_now;
          victim_d = vic_sel;
          if (j_nxt < cnt_l) begin
            j_d     = j_nxt;
            state_d = S_C_RD;
          end else if (i_inc < cnt_l) begin
            i_d     = i_inc;
            state_d = S_K_RDI;
          end else if (found_now) begin
            n_d     = LW'(vic_sel);
            state_d = S_X_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_K_RDI: begin
        rd_addr = i_q[IW-1:0];
        state_d = S_K_LDI;
      end
      S_K_LDI: begin
        ba_d    = rd_box;
        state_d = S_K_AI;
      end
      S_K_AI: begin
        mul_op  = MulAreaA;
        state_d = S_K_AI2;
      end
      S_K_AI2: begin
        area_a_d = prod_lo;
        j_d      = (i_q == '0) ? LW'(1) : '0;
        state_d  = S_C_RD;
      end
      S_X_RD: begin
        rd_addr = n_q[IW-1:0];
        state_d = S_X_LD;
      end
      S_X_LD: begin
        sv_tag_d = rd_tag;
        sv_cls_d = rd_cls;
        state_d  = S_E_RD;
      end
      S_E_RD: begin
        if (n_inc < cnt_l) begin
          rd_addr = n_inc[IW-1:0];
          state_d = S_E_WR;
        end else begin
          state_d = S_E_END;
        end
      end
      S_E_WR: begin
        mem_we    = 1'b1;
        mem_waddr = n_q[IW-1:0];
        mem_wdata = rdata_q;
        n_d       = n_inc;
        state_d   = S_E_RD;
      end
      S_E_END: begin
        res_st_d  = StOk;
        res_tag_d = sv_tag_q;
        res_cls_d = sv_cls_q;
        if (cmd_q == CmdReplace) begin
          // new box lands at the last place, keeping tag and class
          mem_we    = 1'b1;
          mem_waddr = cnt_m1[IW-1:0];
          mem_wdata = {ba_q, sv_tag_q, sv_cls_q};
          res_idx_d = 4'(cnt_m1);
        end else begin
          cnt_d     = cnt_m1;
          res_idx_d = 4'(victim_q);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_idx_d   = res_idx_q;
          out_tag_d   = res_tag_q;
          out_cls_d   = res_cls_q;
          out_cnt_d   = 5'(cnt_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tag_ctr_q   <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      match_thr_q <= MatchThrRst;
      merge_thr_q <= MergeThrRst;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tag_ctr_q   <= tag_ctr_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgMatch) begin
          match_thr_q <= cfg_data_i;
        end else begin
          merge_thr_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cls_in_q  <= cls_in_d;
    slot_q    <= slot_d;
    ba_q      <= ba_d;
    bb_q      <= bb_d;
    bb_tag_q  <= bb_tag_d;
    bb_cls_q  <= bb_cls_d;
    sv_tag_q  <= sv_tag_d;
    sv_cls_q  <= sv_cls_d;
    area_a_q  <= area_a_d;
    ov_q      <= ov_d;
    a_big_q   <= a_big_d;
    i_q       <= i_d;
    j_q       <= j_d;
    n_q       <= n_d;
    victim_q  <= victim_d;
    res_st_q  <= res_st_d;
    res_idx_q <= res_idx_d;
    res_tag_q <= res_tag_d;
    res_cls_q <= res_cls_d;
    out_st_q  <= out_st_d;
    out_idx_q <= out_idx_d;
    out_tag_q <= out_tag_d;
    out_cls_q <= out_cls_d;
    out_cnt_q <= out_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign result_index_o = out_idx_q;
  assign result_tag_o   = out_tag_q;
  assign result_class_o = out_cls_q;
  assign entry_count_o  = out_cnt_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(N))
    else $error("entry count above table size");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word taken while busy");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result word raised outside the done step");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> LW'(mem_waddr) < LW'(N))
    else $error("table write beyond its depth");
`endif

endmodule

@@ test/testbench.sv @@
// testbench for rectangle_track_table: directed table, then random command phases
// checked word by word against an in-bench table predictor; depends on rtt_pkg
`timescale 1ns / 1ps

module testbench;
  import rtt_pkg::*;

  localparam int Entries = 16;
  localparam int WatchdogLimit = 60000;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
  } rect_t;

  typedef struct packed {
    logic [2:0]  cmd;
    rect_t       box;
    logic [7:0]  cls;
    logic [3:0]  slot;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  index;
    logic [15:0] tag;
    logic [7:0]  cls;
    logic [4:0]  count;
  } result_t;

  typedef struct packed {
    cmd_word_t   word;
    logic        typed;
    result_t     res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = '0;
  logic [11:0] box_x_i = '0;
  logic [11:0] box_y_i = '0;
  logic [11:0] box_width_i = '0;
  logic [11:0] box_height_i = '0;
  logic [7:0]  object_class_i = '0;
  logic [3:0]  slot_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  result_index_o;
  logic [15:0] result_tag_o;
  logic [7:0]  result_class_o;
  logic [4:0]  entry_count_o;

  rectangle_track_table u_dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  rect_t       tbl_box [Entries];
  logic [15:0] tbl_tag [Entries];
  logic [7:0]  tbl_cls [Entries];
  int          tbl_count;
  logic [15:0] tag_counter;
  logic [8:0]  match_thr;
  logic [8:0]  merge_thr;

  result_t     pending_results[$];
  int          idle_pct = 27;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  function automatic longint unsigned rect_area(rect_t r);
    return longint'(r.w) * longint'(r.h);
  endfunction

  function automatic longint unsigned overlap(rect_t a, rect_t b);
    longint unsigned x1, y1, x2, y2;
    x1 = (a.x > b.x) ? a.x : b.x;
    y1 = (a.y > b.y) ? a.y : b.y;
    x2 = ((a.x + 13'(a.w)) < (b.x + 13'(b.w))) ? a.x + 13'(a.w) : b.x + 13'(b.w);
    y2 = ((a.y + 13'(a.h)) < (b.y + 13'(b.h))) ? a.y + 13'(a.h) : b.y + 13'(b.h);
    if (x2 <= x1 || y2 <= y1) return 0;
    return (x2 - x1) * (y2 - y1);
  endfunction

  function automatic bit over_thr(longint unsigned ov, logic [8:0] thr,
                                  longint unsigned area);
    return ov * 256 > longint'(thr) * area;
  endfunction

  function automatic void drop_entry(int k);
    for (int n = k; n + 1 < tbl_count; n++) begin
      tbl_box[n] = tbl_box[n+1];
      tbl_tag[n] = tbl_tag[n+1];
      tbl_cls[n] = tbl_cls[n+1];
    end
    if (tbl_count > 0) tbl_count--;
  endfunction

  // appends one expected word at the back of the queue
  task automatic queue_result(result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  function automatic result_t table_step(cmd_word_t w);
    result_t r;
    logic [15:0] t;
    logic [7:0] c;
    int victim, mx;
    bit found;
    r = '0;
    r.status = StNone;
    case (w.cmd)
      CmdInsert: begin
        if (tbl_count >= Entries) begin
          r.status = StFull;
        end else begin
          tbl_box[tbl_count] = w.box;
          tbl_tag[tbl_count] = tag_counter;
          tbl_cls[tbl_count] = w.cls;
          r = '{StOk, 4'(tbl_count), tag_counter, w.cls, 5'd0};
          tbl_count++;
          tag_counter++;
        end
      end
      CmdQuery: begin
        for (int j = 0; j < tbl_count; j++) begin
          if (!found && (over_thr(overlap(w.box, tbl_box[j]), match_thr,
                                  rect_area(tbl_box[j])) ||
                         over_thr(overlap(w.box, tbl_box[j]), match_thr,
                                  rect_area(w.box)))) begin
            found = 1;
            r = '{StOk, 4'(j), tbl_tag[j], tbl_cls[j], 5'd0};
          end
        end
      end
      CmdReplace, CmdRemove: begin
        if (int'(w.slot) >= tbl_count) begin
          r.status = StBadSlot;
        end else begin
          t = tbl_tag[w.slot];
          c = tbl_cls[w.slot];
          drop_entry(w.slot);
          r = '{StOk, w.slot, t, c, 5'd0};
          if (w.cmd == CmdReplace) begin
            tbl_box[tbl_count] = w.box;
            tbl_tag[tbl_count] = t;
            tbl_cls[tbl_count] = c;
            r.index = 4'(tbl_count);
            tbl_count++;
          end
        end
      end
      CmdClean: begin
        victim = 0;
        for (int i = 0; i < tbl_count; i++) begin
          for (int j = 0; j < tbl_count; j++) begin
            if (i != j) begin
              mx = (rect_area(tbl_box[i]) > rect_area(tbl_box[j])) ? i : j;
              if (over_thr(overlap(tbl_box[i], tbl_box[j]), merge_thr,
                           rect_area(tbl_box[mx]))) begin
                victim = mx;
                found = 1;
              end
            end
          end
        end
        if (found) begin
          r = '{StOk, 4'(victim), tbl_tag[victim], tbl_cls[victim], 5'd0};
          drop_entry(victim);
        end
      end
      default: ;
    endcase
    r.count = 5'(tbl_count);
    return r;
  endfunction

  // acceptance edge: valid is driven low for a random gap, then raised with the next word
  task automatic send_word(cmd_word_t w, output result_t predicted);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= w.cmd;
    box_x_i <= w.box.x;
    box_y_i <= w.box.y;
    box_width_i <= w.box.w;
    box_height_i <= w.box.h;
    object_class_i <= w.cls;
    slot_i <= w.slot;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = table_step(w);
  endtask

  task automatic write_thresholds(logic [8:0] m, logic [8:0] g);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgMatch;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_index_i <= CfgMerge;
    cfg_data_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    match_thr = m;
    merge_thr = g;
  endtask

  function automatic cmd_word_t random_word(int insert_pct);
    cmd_word_t w;
    int r, j;
    r = $urandom_range(99);
    if (r < insert_pct) w.cmd = CmdInsert;
    else if (r < insert_pct + 25) w.cmd = CmdQuery;
    else if (r < insert_pct + 40) w.cmd = CmdReplace;
    else if (r < insert_pct + 55) w.cmd = CmdRemove;
    else if (r < 97) w.cmd = CmdClean;
    else w.cmd = 3'($urandom_range(7, 5));
    if ($urandom_range(99) < 20) begin
      w.box = rect_t'(48'({$urandom, $urandom}));
    end else begin
      w.box.x = 12'($urandom_range(400, 200));
      w.box.y = 12'($urandom_range(400, 200));
      w.box.w = 12'($urandom_range(120, 0));
      w.box.h = 12'($urandom_range(120, 0));
    end
    // queries near a held box so that matches happen
    if (w.cmd == CmdQuery && tbl_count > 0 && $urandom_range(1)) begin
      j = $urandom_range(tbl_count - 1);
      w.box = tbl_box[j];
      w.box.x = w.box.x + 12'($urandom_range(10)) - 12'd5;
      w.box.w = w.box.w + 12'($urandom_range(10)) - 12'd5;
    end
    w.cls = 8'($urandom);
    if ($urandom_range(9) == 0) w.slot = 4'($urandom);
    else w.slot = 4'($urandom_range((tbl_count < 15) ? tbl_count : 15));
    return w;
  endfunction

  // output side: random stall, compare, watchdog
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word st=%0d", status_o);
        end else begin
          if (status_o !== pending_results[0].status ||
              result_index_o !== pending_results[0].index ||
              result_tag_o !== pending_results[0].tag ||
              result_class_o !== pending_results[0].cls ||
              entry_count_o !== pending_results[0].count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp st=%0d idx=%0d tag=%0d cls=%0d cnt=%0d",
                       pending_results[0].status, pending_results[0].index,
                       pending_results[0].tag, pending_results[0].cls,
                       pending_results[0].count);
              $display("         got st=%0d idx=%0d tag=%0d cls=%0d cnt=%0d",
                       status_o, result_index_o, result_tag_o, result_class_o,
                       entry_count_o);
            end
          end
          void'(pending_results.pop_front());
        end
      end
    end
  end

  initial begin
    row_t directed [18];
    result_t predicted;
    logic [8:0] phase_match [6];
    logic [8:0] phase_merge [6];
    directed = '{
      '{'{3'(CmdQuery),   48'h0, 8'd0, 4'd0}, 1'b1, '{StNone, 4'd0, 16'd0, 8'd0, 5'd0}},
      '{'{3'(CmdRemove),  48'h0, 8'd0, 4'd0}, 1'b1, '{StBadSlot, 4'd0, 16'd0, 8'd0, 5'd0}},
      '{'{3'(CmdReplace), 48'h0, 8'd0, 4'd0}, 1'b1, '{StBadSlot, 4'd0, 16'd0, 8'd0, 5'd0}},
      '{'{3'(CmdClean),   48'h0, 8'd0, 4'd0}, 1'b1, '{StNone, 4'd0, 16'd0, 8'd0, 5'd0}},
      '{'{3'd7,           48'hffffffffffff, 8'hff, 4'hf}, 1'b1,
        '{StNone, 4'd0, 16'd0, 8'd0, 5'd0}},
      '{'{3'(CmdInsert),  {12'hfff, 12'hfff, 12'hfff, 12'hfff}, 8'd255, 4'hf}, 1'b1,
        '{StOk, 4'd0, 16'd0, 8'd255, 5'd1}},
      '{'{3'(CmdInsert),  48'h0, 8'd0, 4'd0}, 1'b1, '{StOk, 4'd1, 16'd1, 8'd0, 5'd2}},
      '{'{3'(CmdInsert),  {12'd100, 12'd100, 12'd50, 12'd50}, 8'd7, 4'd0}, 1'b1,
        '{StOk, 4'd2, 16'd2, 8'd7, 5'd3}},
      '{'{3'(CmdQuery),   {12'd100, 12'd100, 12'd50, 12'd50}, 8'd0, 4'd0}, 1'b0, '0},
      '{'{3'(CmdQuery),   {12'd3000, 12'd3000, 12'd10, 12'd10}, 8'd0, 4'd0}, 1'b0, '0},
      '{'{3'(CmdInsert),  {12'd110, 12'd110, 12'd50, 12'd50}, 8'd9, 4'd0}, 1'b1,
        '{StOk, 4'd3, 16'd3, 8'd9, 5'd4}},
      '{'{3'(CmdClean),   48'h0, 8'd0, 4'd0}, 1'b0, '0},
      '{'{3'(CmdInsert),  {12'd105, 12'd105, 12'd50, 12'd50}, 8'd3, 4'd0}, 1'b0, '0},
      '{'{3'(CmdClean),   48'h0, 8'd0, 4'd0}, 1'b0, '0},
      '{'{3'(CmdReplace), {12'd200, 12'd200, 12'd20, 12'd20}, 8'd99, 4'd1}, 1'b0, '0},
      '{'{3'(CmdRemove),  48'h0, 8'd0, 4'd15}, 1'b0, '0},
      '{'{3'(CmdRemove),  48'h0, 8'd0, 4'd0}, 1'b0, '0},
      '{'{3'd5,           48'h0, 8'd0, 4'd0}, 1'b0, '0}
    };
    phase_match = '{9'd128, 9'd0, 9'd511, 9'd0, 9'd64, 9'd200};
    phase_merge = '{9'd179, 9'd0, 9'd511, 9'd0, 9'd300, 9'd100};
    phase_match[3] = 9'($urandom);
    phase_merge[3] = 9'($urandom);
    tbl_count = 0;
    tag_counter = '0;
    match_thr = MatchThrRst;
    merge_thr = MergeThrRst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      send_word(directed[k].word, predicted);
      queue_result(directed[k].typed ? directed[k].res : predicted);
    end

    for (int p = 0; p < 6; p++) begin
      write_thresholds(phase_match[p], phase_merge[p]);
      idle_pct = (p == 2) ? 0 : 27;
      for (int n = 0; n < 300; n++) begin
        send_word(random_word((p % 2 == 0) ? 55 : 25), predicted);
        queue_result(predicted);
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rtt_pkg.sv
design/rtt_arith.sv
design/rectangle_track_table.sv
test/testbench.sv
